FILE: rtl/core/iira_pkg.sv
// ----------------------------------------------------------------------------
// iira_pkg
// Shared types and codes of the indexed insert/remove array.
// ----------------------------------------------------------------------------
package iira_pkg;

  // request kinds carried in the input tuser
  typedef enum logic [2:0] {
    REQ_WRITE      = 3'd0,
    REQ_READ       = 3'd1,
    REQ_PUSH_END   = 3'd2,
    REQ_PUSH_FRONT = 3'd3,
    REQ_POP_END    = 3'd4,
    REQ_POP_FRONT  = 3'd5,
    REQ_INSERT_AT  = 3'd6,
    REQ_REMOVE_AT  = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  localparam int unsigned PosBits    = 6;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned CountBits  = 7;
  localparam int unsigned CapBits    = 7;
  localparam int unsigned InDataBits = 40;
  localparam int unsigned OutDataBits = 40;
  localparam logic [CapBits-1:0] CapReset = 7'd64;

  // per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

  // result of one request as seen by the output stage
  typedef struct packed {
    status_e              status;
    logic                 rd_en;
    logic [CountBits-1:0] count;
  } resp_t;

endpackage

FILE: rtl/core/iira_cell.sv
// ----------------------------------------------------------------------------
// iira_cell
// One element slot: holds a word, loads, or takes its neighbor's word.
// ----------------------------------------------------------------------------
module iira_cell #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned IDX       = 0,
  parameter int unsigned CMPW      = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iira_pkg::cell_ctl_t   ctl_i,
  input  logic [CMPW-1:0]       lo_i,
  input  logic [CMPW-1:0]       hi_i,
  input  logic [WORD_BITS-1:0]  word_i,
  input  logic [WORD_BITS-1:0]  left_i,
  input  logic [WORD_BITS-1:0]  right_i,
  output logic [WORD_BITS-1:0]  word_o
);

  localparam logic [CMPW-1:0] Index = CMPW'(IDX);

  logic [WORD_BITS-1:0] word_d, word_q;

  always_comb begin
    word_d = word_q;
    if (ctl_i.load && (Index == lo_i)) begin
      word_d = word_i;
    end else if (ctl_i.shift_up && (Index > lo_i) && (Index <= hi_i)) begin
      word_d = left_i;
    end else if (ctl_i.shift_down && (Index >= lo_i) && (Index < hi_i)) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

FILE: rtl/core/iira_ctrl.sv
// ----------------------------------------------------------------------------
// iira_ctrl
// Request decode, range checks and live element count.
// ----------------------------------------------------------------------------
module iira_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned CW    = 7,
  parameter int unsigned CMPW  = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  iira_pkg::req_e                  req_i,
  input  logic [iira_pkg::PosBits-1:0]    pos_i,
  input  logic [iira_pkg::CapBits-1:0]    cap_cfg_i,
  output iira_pkg::cell_ctl_t             ctl_o,
  output logic [CMPW-1:0]                 lo_o,
  output logic [CMPW-1:0]                 hi_o,
  output iira_pkg::resp_t                 resp_o
);

  localparam logic [CMPW-1:0] DepthC = CMPW'(DEPTH);
  localparam logic [CMPW-1:0] One    = CMPW'(1);

  logic [CW-1:0]   count_d, count_q;
  logic [CMPW-1:0] n, cap, pos, p, n_next;
  logic [CMPW-1:0] cap_raw;
  iira_pkg::status_e   st;
  iira_pkg::cell_ctl_t ctl;
  logic            rd_en;

  // clamp the capacity register to 1..DEPTH
  always_comb begin
    cap_raw = CMPW'(cap_cfg_i);
    if (cap_raw == '0) begin
      cap = One;
    end else if (cap_raw > DepthC) begin
      cap = DepthC;
    end else begin
      cap = cap_raw;
    end
  end

  always_comb begin
    n      = CMPW'(count_q);
    pos    = CMPW'(pos_i);
    p      = pos;
    n_next = n;
    st     = iira_pkg::ST_OK;
    ctl    = '0;
    rd_en  = 1'b0;
    hi_o   = n;
    case (req_i)
      iira_pkg::REQ_WRITE: begin
        if (pos >= cap) begin
          st = iira_pkg::ST_RANGE;
        end else begin
          ctl.load = 1'b1;
          if (pos + One > n) n_next = pos + One;
        end
      end
      iira_pkg::REQ_READ: begin
        if (pos >= n) begin
          st = iira_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      iira_pkg::REQ_PUSH_END, iira_pkg::REQ_PUSH_FRONT, iira_pkg::REQ_INSERT_AT: begin
        if (req_i == iira_pkg::REQ_PUSH_END) begin
          p = n;
        end else if (req_i == iira_pkg::REQ_PUSH_FRONT) begin
          p = '0;
        end
        if (p > n) begin
          st = iira_pkg::ST_RANGE;
        end else if (n >= cap) begin
          st = iira_pkg::ST_FULL;
        end else begin
          ctl.load     = 1'b1;
          ctl.shift_up = 1'b1;
          n_next       = n + One;
        end
      end
      default: begin
        if (req_i == iira_pkg::REQ_POP_END) begin
          p = n - One;
        end else if (req_i == iira_pkg::REQ_POP_FRONT) begin
          p = '0;
        end
        hi_o = n - One;
        if (n == '0) begin
          st = iira_pkg::ST_EMPTY;
        end else if (p >= n) begin
          st = iira_pkg::ST_RANGE;
        end else begin
          rd_en          = 1'b1;
          ctl.shift_down = 1'b1;
          n_next         = n - One;
        end
      end
    endcase
    lo_o = p;
    // cells move only on an accepted request
    ctl_o = accept_i ? ctl : '0;
    count_d = accept_i ? CW'(n_next) : count_q;
    resp_o.status = st;
    resp_o.rd_en  = rd_en;
    resp_o.count  = iira_pkg::CountBits'(n_next);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/core/indexed_insert_remove_array.sv
// The result of an accepted request is registered and shows on the master side in the next cycle.
// Throughput: one request per cycle unless the output stalls; every slot of the cell
// chain shifts in the same cycle: inserts and removes cost the same as reads and writes.
// Reset: all slots and the live count clear to zero, capacity returns to 64;
// no clearing pass, requests are taken as soon as reset is released.
// ----------------------------------------------------------------------------
// indexed_insert_remove_array
// Ordered array of signed words with indexed insert/remove over a cell chain.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // capacity_in_use
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // position[5:0], item_value[37:6], zero[39:38]
  input  logic [2:0]  s_axis_tuser_i,   // req_type[2:0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // read_value[31:0], element_count[38:32], zero[39]
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > iira_pkg::CapBits) ? CW : iira_pkg::CapBits;

  logic [iira_pkg::CapBits-1:0] cap_q;
  logic                         accept;
  iira_pkg::cell_ctl_t          ctl;
  logic [CMPW-1:0]              lo, hi;
  iira_pkg::resp_t              resp;
  logic [63:0]                  in_ext;
  logic [WORD_BITS-1:0]         in_word;
  logic [WORD_BITS-1:0]         cell_word [DEPTH];
  logic [WORD_BITS-1:0]         rd_word;
  logic [63:0]                  rd_ext;

  logic                         out_valid_q;
  logic [31:0]                  rd_value_d, rd_value_q;
  logic [6:0]                   count_q;
  iira_pkg::status_e            status_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= iira_pkg::CapReset;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_ext  = {32'd0, s_axis_tdata_i[37:6]};
  assign in_word = in_ext[WORD_BITS-1:0];

  iira_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .CMPW  (CMPW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (iira_pkg::req_e'(s_axis_tuser_i)),
    .pos_i     (s_axis_tdata_i[5:0]),
    .cap_cfg_i (cap_q),
    .ctl_o     (ctl),
    .lo_o      (lo),
    .hi_o      (hi),
    .resp_o    (resp)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    iira_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX       (i),
      .CMPW      (CMPW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .lo_i    (lo),
      .hi_i    (hi),
      .word_i  (in_word),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[i])
    );
  end

  // select the addressed slot before this cycle's shift lands
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CMPW'(i) == lo) rd_word = rd_word | cell_word[i];
    end
  end

  assign rd_ext     = 64'($signed(rd_word));
  assign rd_value_d = resp.rd_en ? rd_ext[31:0] : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result until the request downstream takes it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_value_q <= rd_value_d;
      count_q    <= resp.count;
      status_q   <= resp.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, count_q, rd_value_q};
  assign m_axis_tuser_o  = status_q;

endmodule
